// File: sv/h264rtp_pkg.sv
`default_nettype none
package h264rtp_pkg;

    // NAL length field width
    localparam int unsigned LENGTH_BITS = 16;

    // configuration register indexes
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_TS_STEP     = 1'b1;
    localparam int unsigned CFG_DATA_W = 17;

    // register reset values and payload limit clamp
    localparam logic [12:0] MAX_PAYLOAD_RST = 13'd1400;
    localparam logic [16:0] TS_STEP_RST     = 17'd3600;
    localparam logic [12:0] PAYLOAD_MIN     = 13'd16;
    localparam logic [12:0] PAYLOAD_MAX     = 13'd4096;

    // NAL / FU-A codes
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
    localparam logic [7:0] FU_A_TYPE     = 8'd28;
    localparam logic [7:0] FU_S_BIT      = 8'h80;
    localparam logic [7:0] FU_E_BIT      = 8'h40;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;

    // maximum results per request
    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic [LENGTH_BITS-1:0] nal_length;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_start;
        logic        packet_end;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic        last_of_item;
    } t_out;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] byte_count;
        logic [12:0]            fragment_fill;
        logic [7:0]             unit_header;
        logic                   fragmenting;
        logic [15:0]            seq_counter;
        logic [31:0]            ts_counter;
    } t_state;

endpackage
`default_nettype wire

// File: sv/h264rtp_frag.sv
`default_nettype none
// Per-byte packetiser decision: results for one NAL byte and the next state.
module h264rtp_frag (
    input  wire h264rtp_pkg::t_state              i_state,
    input  wire h264rtp_pkg::t_in                 i_in,
    input  wire [12:0]                            i_max_payload,
    input  wire [16:0]                            i_ts_step,
    output h264rtp_pkg::t_out [h264rtp_pkg::MAX_RES-1:0] o_res,
    output logic [1:0]                            o_n,
    output h264rtp_pkg::t_state                   o_state
);
    localparam int unsigned LB = h264rtp_pkg::LENGTH_BITS;

    logic [12:0]   mp;
    logic [LB-1:0] len;
    logic [LB-1:0] cnt;
    logic          first;
    logic          last;
    logic [7:0]    hdr;
    logic          frag;
    logic [12:0]   fill;
    logic [12:0]   fill_inc;
    logic          pend;
    logic          tail_fits;
    logic [7:0]    fu_hdr;
    logic [4:0]    ntype;
    logic [LB-1:0] remain;

    always_comb begin
        // clamp payload limit
        mp = i_max_payload;
        if (mp < h264rtp_pkg::PAYLOAD_MIN) mp = h264rtp_pkg::PAYLOAD_MIN;
        if (mp > h264rtp_pkg::PAYLOAD_MAX) mp = h264rtp_pkg::PAYLOAD_MAX;

        len   = (i_in.nal_length == '0) ? LB'(1) : i_in.nal_length;
        cnt   = i_state.byte_count;
        first = (cnt == '0);
        last  = ({1'b0, cnt} + (LB+1)'(1)) >= {1'b0, len};

        // unit header byte latches mode
        hdr  = first ? i_in.data_byte : i_state.unit_header;
        frag = first ? ({1'b0, len} > (LB+1)'(mp)) : i_state.fragmenting;
        fill = first ? '0 : i_state.fragment_fill;

        fill_inc  = fill + 13'd1;
        pend      = last || (fill_inc >= mp);
        remain    = len - cnt;
        tail_fits = (len > cnt) && ({1'b0, remain} <= (LB+1)'(mp));
        ntype     = hdr[4:0];

        fu_hdr = hdr & h264rtp_pkg::NAL_TYPE_MASK;
        if (cnt == LB'(1)) fu_hdr = fu_hdr | h264rtp_pkg::FU_S_BIT;
        if (last || tail_fits) fu_hdr = fu_hdr | h264rtp_pkg::FU_E_BIT;

        // defaults: results carry current seq/ts
        for (int k = 0; k < int'(h264rtp_pkg::MAX_RES); k++) begin
            o_res[k].out_byte     = i_in.data_byte;
            o_res[k].packet_start = 1'b0;
            o_res[k].packet_end   = 1'b0;
            o_res[k].seq_number   = i_state.seq_counter;
            o_res[k].time_stamp   = i_state.ts_counter;
            o_res[k].last_of_item = 1'b0;
        end
        o_n     = 2'd0;
        o_state = i_state;
        o_state.unit_header   = hdr;
        o_state.fragmenting   = frag;
        o_state.fragment_fill = fill;

        if (!frag) begin
            // single NAL unit packet
            o_res[0].packet_start = first;
            o_res[0].packet_end   = last;
            o_res[0].last_of_item = 1'b1;
            o_n = 2'd1;
            if (last) begin
                o_state.seq_counter = i_state.seq_counter + 16'd1;
                if (ntype != h264rtp_pkg::NAL_SPS && ntype != h264rtp_pkg::NAL_PPS)
                    o_state.ts_counter = i_state.ts_counter + 32'(i_ts_step);
            end
        end else if (!first) begin
            if (fill == '0) begin
                // open a fragment: indicator and FU header ahead of the data byte
                o_res[0].out_byte     = (hdr & h264rtp_pkg::NAL_NRI_MASK)
                                        | h264rtp_pkg::FU_A_TYPE;
                o_res[0].packet_start = 1'b1;
                o_res[1].out_byte     = fu_hdr;
                o_res[2].packet_end   = pend;
                o_res[2].last_of_item = 1'b1;
                o_n = 2'd3;
            end else begin
                o_res[0].packet_end   = pend;
                o_res[0].last_of_item = 1'b1;
                o_n = 2'd1;
            end
            o_state.fragment_fill = pend ? 13'd0 : fill_inc;
            if (pend) o_state.seq_counter = i_state.seq_counter + 16'd1;
            if (last) o_state.ts_counter = i_state.ts_counter + 32'(i_ts_step);
        end

        // byte counter and end of unit
        if (last) begin
            o_state.byte_count    = '0;
            o_state.fragment_fill = '0;
            o_state.fragmenting   = 1'b0;
        end else begin
            o_state.byte_count = cnt + LB'(1);
        end
    end

endmodule
`default_nettype wire

// File: sv/h264_nal_rtp_packetizer.sv
`default_nettype none
// H.264 NAL to RTP payload packetiser with FU-A fragmentation.
// Input channel (i_valid/o_ready, i_in): one NAL byte per request, header
// byte first, each tagged with the unit's total length.
// Output channel (o_valid/i_ready, o_out): RTP payload bytes with packet
// start/end marks, sequence number and timestamp of their packet.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 max_payload,
// 1 timestamp_step) with no wait; write only while idle.
// Latency: the first result of a request is offered the cycle after it is
// accepted. Throughput: one byte per cycle while the receiver takes results;
// the byte that opens a FU-A fragment yields three results and holds the input
// until the three-entry result queue, draining one entry per cycle, holds one.
// The header byte of a fragmented unit yields no result.
// A new request is taken while the last queued result is being taken.
// Receiver stall: the queue holds and o_ready drops until it is drained.
// Reset: counters, sequence and timestamp clear to zero, max_payload 1400,
// timestamp_step 3600, queue empty.
module h264_nal_rtp_packetizer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire h264rtp_pkg::t_in                 i_in,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output h264rtp_pkg::t_out                     o_out,
    input  wire                                   i_cfg_we,
    input  wire                                   i_cfg_idx,
    input  wire [h264rtp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    h264rtp_pkg::t_state                          r_state;
    h264rtp_pkg::t_state                          n_state;
    h264rtp_pkg::t_out [h264rtp_pkg::MAX_RES-1:0] r_slot;
    h264rtp_pkg::t_out [h264rtp_pkg::MAX_RES-1:0] n_res;
    logic [1:0]                                   r_cnt;
    logic [1:0]                                   n_cnt;
    logic [12:0]                                  r_max_payload;
    logic [16:0]                                  r_ts_step;
    logic                                         take;
    logic                                         accept;

    h264rtp_frag u_frag (
        .i_state       (r_state),
        .i_in          (i_in),
        .i_max_payload (r_max_payload),
        .i_ts_step     (r_ts_step),
        .o_res         (n_res),
        .o_n           (n_cnt),
        .o_state       (n_state)
    );

    // handshakes
    assign o_valid = (r_cnt != 2'd0);
    assign o_out   = r_slot[0];
    assign take    = o_valid && i_ready;
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign accept  = i_valid && o_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= h264rtp_pkg::MAX_PAYLOAD_RST;
            r_ts_step     <= h264rtp_pkg::TS_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                h264rtp_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[12:0];
                h264rtp_pkg::CFG_TS_STEP:     r_ts_step     <= i_cfg_data;
                default:                      r_ts_step     <= r_ts_step;
            endcase
        end
    end

    // packetiser state and result queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= 2'd0;
        end else if (accept) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end else if (take) begin
            r_cnt   <= r_cnt - 2'd1;
        end
    end

    // result queue payload: load on accept, shift on take
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= n_res;
        end else if (take) begin
            for (int k = 0; k < int'(h264rtp_pkg::MAX_RES) - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

endmodule
`default_nettype wire
